FILE: rtl/aie_pkg.sv
// ----------------------------------------------------------------------------
// aie_pkg
// Types and constants shared by the accumulator instruction executor.
// ----------------------------------------------------------------------------
package aie_pkg;

    localparam int DATA_W  = 32;
    localparam int ROW_W   = 11;
    localparam int OPC_W   = 4;
    localparam int ARG_W   = 16;
    localparam int STAT_W  = 2;
    localparam int LEVEL_W = 2;
    localparam int CFG_W   = 11;   // widest register: program_rows
    localparam int CFGI_W  = 1;

    // highest row count honored; larger program_rows values are clamped
    localparam logic [ROW_W-1:0] MAX_ROWS = 11'd1024;

    // slots reachable at the highest level (0..3)
    localparam int LEVEL_SLOTS = 4;

    // operation codes; all other codes are malformed
    localparam logic [OPC_W-1:0] OP_INBOX    = 4'd0;
    localparam logic [OPC_W-1:0] OP_OUTBOX   = 4'd1;
    localparam logic [OPC_W-1:0] OP_ADD      = 4'd2;
    localparam logic [OPC_W-1:0] OP_SUB      = 4'd3;
    localparam logic [OPC_W-1:0] OP_COPYTO   = 4'd4;
    localparam logic [OPC_W-1:0] OP_COPYFROM = 4'd5;
    localparam logic [OPC_W-1:0] OP_JUMP     = 4'd6;
    localparam logic [OPC_W-1:0] OP_JUMPZ    = 4'd7;

    // run status codes
    localparam logic [STAT_W-1:0] ST_RUNNING  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FINISHED = 2'd1;
    localparam logic [STAT_W-1:0] ST_ERROR    = 2'd2;

    // level codes
    localparam logic [LEVEL_W-1:0] LVL_NONE  = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_BASIC = 2'd1;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_GAME_LEVEL   = 1'd0;
    localparam logic [CFGI_W-1:0] CFG_PROGRAM_ROWS = 1'd1;

    typedef struct packed {
        logic [OPC_W-1:0]         operation;
        logic [ARG_W-1:0]         operand;
        logic                     inbox_has_item;
        logic signed [DATA_W-1:0] inbox_value;
    } aie_in_t;

    typedef struct packed {
        logic [ROW_W-1:0]         next_row;
        logic [STAT_W-1:0]        run_status;
        logic [ROW_W-1:0]         error_row;
        logic                     outbox_valid;
        logic signed [DATA_W-1:0] outbox_value;
        logic                     inbox_taken;
    } aie_out_t;

endpackage

FILE: rtl/accumulator_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// accumulator_instruction_executor_core
// Executes one decoded instruction per beat for a small accumulator machine.
// ----------------------------------------------------------------------------
// One instruction per clock, one beat per cycle sustained while the output is
// not stalled. A beat is captured in an input register, executed by one pass of
// logic against the hand, slot, row and halt registers, and the result lands in
// an output register. The machine state is updated in the same cycle the result
// register loads, so the following beat always sees it. A stalled output holds
// the beat in the input register, which then takes no new beat. Once the machine
// halts (finished or error) every later beat reports the stored status again
// until reset. Configuration is to be written through cfg_we/cfg_index/cfg_data
// only while no beat is in flight; the block itself does not enforce this.
module accumulator_instruction_executor_core
    import aie_pkg::*;
#(
    parameter int SLOT_COUNT = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  aie_in_t              in_data,

    output logic                 out_valid,
    input  logic                 out_ready,
    output aie_out_t             out_data,

    input  logic                 cfg_we,
    input  logic [CFGI_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int USED_SLOTS = (SLOT_COUNT < LEVEL_SLOTS) ? SLOT_COUNT : LEVEL_SLOTS;
    localparam int SLOT_W     = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
    localparam int SLOT_DEPTH = 1 << SLOT_W;

    // pipeline registers
    logic                     in_valid_reg;
    aie_in_t                  in_data_reg;
    logic                     out_valid_reg;
    aie_out_t                 out_data_reg;

    // machine state
    logic [DATA_W-1:0]        hand_value_reg, hand_value_next;
    logic                     hand_full_reg, hand_full_next;
    logic [DATA_W-1:0]        slot_value_reg [SLOT_DEPTH];
    logic [SLOT_DEPTH-1:0]    slot_valid_reg;
    logic [ROW_W-1:0]         current_row_reg, current_row_next;
    logic                     halted_reg, halted_next;
    logic                     halt_err_reg, halt_err_next;

    // configuration
    logic [LEVEL_W-1:0]       game_level_reg;
    logic [CFG_W-1:0]         program_rows_reg;

    logic                     advance;
    logic [ROW_W-1:0]         rows;
    logic [ARG_W-1:0]         arg;
    logic [SLOT_W-1:0]        sidx;
    logic                     slot_ok;
    logic                     slot_rd_ok;
    logic [DATA_W-1:0]        slot_rd;
    logic                     jump_ok;
    logic                     err;
    logic                     fin;
    logic [ROW_W-1:0]         row_target;
    logic                     slot_we;
    aie_out_t                 result;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign rows = (program_rows_reg > MAX_ROWS) ? MAX_ROWS : program_rows_reg;
    assign arg  = in_data_reg.operand;
    assign sidx = arg[SLOT_W-1:0];

    // level 0 reaches no slot, level 1 only slot 0, higher levels slots 0..3; all below SLOT_COUNT
    always_comb
    begin
        case (game_level_reg)
            LVL_NONE:  slot_ok = 1'b0;
            LVL_BASIC: slot_ok = (arg == '0);
            default:   slot_ok = (arg < ARG_W'(LEVEL_SLOTS));
        endcase
        slot_ok = slot_ok && (arg < ARG_W'(SLOT_COUNT));
    end

    assign slot_rd    = slot_value_reg[sidx];
    assign slot_rd_ok = slot_ok && slot_valid_reg[sidx];
    assign jump_ok    = (arg != '0) && (arg <= ARG_W'(rows));

    always_comb
    begin
        hand_value_next  = hand_value_reg;
        hand_full_next   = hand_full_reg;
        current_row_next = current_row_reg;
        halted_next      = halted_reg;
        halt_err_next    = halt_err_reg;
        err              = 1'b0;
        fin              = 1'b0;
        slot_we          = 1'b0;
        row_target       = current_row_reg + ROW_W'(1);
        result           = '0;

        if (!halted_reg)
        begin
            if (current_row_reg > rows)
            begin
                fin = 1'b1;
            end
            else if (game_level_reg == LVL_BASIC && in_data_reg.operation >= OP_ADD)
            begin
                err = 1'b1;
            end
            else
            begin
                case (in_data_reg.operation)
                    OP_INBOX:
                    begin
                        if (!in_data_reg.inbox_has_item)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            hand_value_next    = in_data_reg.inbox_value;
                            hand_full_next     = 1'b1;
                            result.inbox_taken = 1'b1;
                        end
                    end
                    OP_OUTBOX:
                    begin
                        if (!hand_full_reg)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            result.outbox_valid = 1'b1;
                            result.outbox_value = hand_value_reg;
                            hand_full_next      = 1'b0;
                            hand_value_next     = '0;
                        end
                    end
                    OP_ADD, OP_SUB:
                    begin
                        if (!hand_full_reg || !slot_rd_ok)
                            err = 1'b1;
                        else if (in_data_reg.operation == OP_ADD)
                            hand_value_next = hand_value_reg + slot_rd;
                        else
                            hand_value_next = hand_value_reg - slot_rd;
                    end
                    OP_COPYTO:
                    begin
                        if (!hand_full_reg || !slot_ok)
                            err = 1'b1;
                        else
                            slot_we = 1'b1;
                    end
                    OP_COPYFROM:
                    begin
                        if (!slot_rd_ok)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            hand_value_next = slot_rd;
                            hand_full_next  = 1'b1;
                        end
                    end
                    OP_JUMP:
                    begin
                        if (!jump_ok)
                            err = 1'b1;
                        else
                            row_target = arg[ROW_W-1:0];
                    end
                    OP_JUMPZ:
                    begin
                        if (!hand_full_reg || !jump_ok)
                            err = 1'b1;
                        else if (hand_value_reg == '0)
                            row_target = arg[ROW_W-1:0];
                    end
                    default:
                    begin
                        err = 1'b1;
                    end
                endcase

                if (!err && !fin)
                begin
                    current_row_next = row_target;
                    if (row_target > rows)
                        fin = 1'b1;
                end
            end

            if (err || fin)
            begin
                halted_next   = 1'b1;
                halt_err_next = err;
            end
        end

        // an error leaves hand, slots and row untouched
        if (err)
        begin
            hand_value_next  = hand_value_reg;
            hand_full_next   = hand_full_reg;
        end

        result.next_row = current_row_next;
        if (halted_next)
        begin
            result.run_status = halt_err_next ? ST_ERROR : ST_FINISHED;
            result.error_row  = halt_err_next ? current_row_next : '0;
        end
        else
        begin
            result.run_status = ST_RUNNING;
            result.error_row  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            hand_value_reg   <= '0;
            hand_full_reg    <= 1'b0;
            slot_valid_reg   <= '0;
            current_row_reg  <= ROW_W'(1);
            halted_reg       <= 1'b0;
            halt_err_reg     <= 1'b0;
            game_level_reg   <= LVL_BASIC;
            program_rows_reg <= CFG_W'(1);
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                hand_value_reg  <= hand_value_next;
                hand_full_reg   <= hand_full_next;
                current_row_reg <= current_row_next;
                halted_reg      <= halted_next;
                halt_err_reg    <= halt_err_next;
                if (slot_we)
                    slot_valid_reg[sidx] <= 1'b1;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GAME_LEVEL:   game_level_reg   <= cfg_data[LEVEL_W-1:0];
                    CFG_PROGRAM_ROWS: program_rows_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= result;
        if (advance && slot_we)
            slot_value_reg[sidx] <= hand_value_reg;
    end

    // once halted, the machine never resumes and the row is frozen
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg && $stable(current_row_reg))
        else $error("halted machine changed state");

    // error row is reported exactly when status is error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.run_status == ST_ERROR) ==
                           (out_data_reg.error_row != '0)))
        else $error("error_row disagrees with run_status");

    // one instruction never both reads the inbox and writes the outbox
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.outbox_valid && out_data_reg.inbox_taken))
        else $error("inbox and outbox in the same beat");

    // an executed beat whose result says running leaves the machine running
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.run_status == ST_RUNNING |=> !halted_reg)
        else $error("running result but machine halted");

endmodule
